@@ hdl/l4_packet_checksum_macros.svh @@
// Assertion macros for the checksum block.
`ifndef L4_PACKET_CHECKSUM_MACROS_SVH
`define L4_PACKET_CHECKSUM_MACROS_SVH

`ifndef SYNTHESIS
`define LPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define LPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define LPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/lpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

    localparam int LPC_MAX_FRAME_BYTES = 8192;

    localparam int LIMIT_W    = 14;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_UDP_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TCP_LIMIT = 8'd1;

    localparam logic [LIMIT_W-1:0] UDP_LIMIT_RESET = 14'd1480;
    localparam logic [LIMIT_W-1:0] TCP_LIMIT_RESET = 14'd4096;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // frame offsets
    localparam int POS_IHL     = 14;
    localparam int POS_LEN_HI  = 16;
    localparam int POS_LEN_LO  = 17;
    localparam int POS_PROTO   = 23;
    localparam int POS_SRC_LO  = 26;
    localparam int POS_SRC_HI  = 29;
    localparam int POS_DST_LO  = 30;
    localparam int POS_DST_HI  = 33;
    localparam int L4_START    = 34;
    localparam int TCP_MIN_LEN = 54;
    localparam int UDP_MIN_LEN = 42;
    localparam int UDP_LEN_K0  = 4;
    localparam int UDP_LEN_K1  = 5;

    localparam logic [1:0] ST_TCP_OK = 2'd0;
    localparam logic [1:0] ST_UDP_OK = 2'd1;
    localparam logic [1:0] ST_OTHER  = 2'd2;
    localparam logic [1:0] ST_TRUNC  = 2'd3;

    localparam int SUM_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [15:0] checksum;
        logic [1:0]  status;
    } out_word_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] udp_sum_limit;
        logic [LIMIT_W-1:0] tcp_sum_limit;
    } cfg_limits_t;

    // one finished frame, handed from the byte parser to the finisher
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] running_sum;
        logic [7:0]  pending_high_byte;
        logic        odd_tail;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [7:0]  protocol_number;
        logic [15:0] ip_total_length;
        logic [3:0]  header_words;
        logic [15:0] udp_length_field;
    } summary_t;

endpackage

`default_nettype wire

@@ hdl/lpc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic      [W-1:0] pop_data,
    output logic              empty,
    output logic              full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lpc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpc_front
    import lpc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = LPC_MAX_FRAME_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire in_word_t    word,
    input  wire cfg_limits_t limits,
    output logic             sum_push,
    output summary_t         summary
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      sum_reg, sum_next;
    logic [7:0]       pend_reg, pend_next;
    logic             half_reg, half_next;
    logic [31:0]      src_reg, src_next;
    logic [31:0]      dst_reg, dst_next;
    logic [7:0]       proto_reg, proto_next;
    logic [15:0]      totlen_reg, totlen_next;
    logic [3:0]       ihl_reg, ihl_next;
    logic [15:0]      udplen_reg, udplen_next;

    logic [7:0]         b;
    logic [POS_W-1:0]   k;
    logic [LIMIT_W-1:0] lim;
    logic               is_tcp, is_udp;

    assign b = word.frame_byte;

    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        pend_next   = pend_reg;
        half_next   = half_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        proto_next  = proto_reg;
        totlen_next = totlen_reg;
        ihl_next    = ihl_reg;
        udplen_next = udplen_reg;
        k           = pos_reg - POS_W'(L4_START);
        lim         = (proto_reg == PROTO_TCP) ? limits.tcp_sum_limit : limits.udp_sum_limit;

        if (pos_reg < MAX_POS)
        begin
            if (pos_reg == POS_W'(POS_IHL))
            begin
                ihl_next = b[3:0];
            end
            else if (pos_reg == POS_W'(POS_LEN_HI) || pos_reg == POS_W'(POS_LEN_LO))
            begin
                totlen_next = {totlen_reg[7:0], b};
            end
            else if (pos_reg == POS_W'(POS_PROTO))
            begin
                proto_next = b;
            end
            else if (pos_reg >= POS_W'(POS_SRC_LO) && pos_reg <= POS_W'(POS_SRC_HI))
            begin
                src_next = {src_reg[23:0], b};
            end
            else if (pos_reg >= POS_W'(POS_DST_LO) && pos_reg <= POS_W'(POS_DST_HI))
            begin
                dst_next = {dst_reg[23:0], b};
            end

            if (pos_reg >= POS_W'(L4_START))
            begin
                if (proto_reg == PROTO_UDP
                    && (k == POS_W'(UDP_LEN_K0) || k == POS_W'(UDP_LEN_K1)))
                begin
                    udplen_next = {udplen_reg[7:0], b};
                end
                if (CMP_W'(k) < CMP_W'(lim))
                begin
                    if (!k[0])
                    begin
                        pend_next = b;
                        half_next = 1'b1;
                    end
                    else
                    begin
                        sum_next  = sum_reg + {16'h0000, pend_reg, b};
                        half_next = 1'b0;
                    end
                end
            end
            pos_next = pos_reg + 1'b1;
        end
    end

    assign is_tcp = (proto_next == PROTO_TCP);
    assign is_udp = (proto_next == PROTO_UDP);

    always_comb
    begin
        if (pos_next < POS_W'(L4_START) || (!is_tcp && !is_udp))
        begin
            summary.status = ST_OTHER;
        end
        else if (is_tcp && pos_next < POS_W'(TCP_MIN_LEN))
        begin
            summary.status = ST_TRUNC;
        end
        else if (is_udp && pos_next < POS_W'(UDP_MIN_LEN))
        begin
            summary.status = ST_TRUNC;
        end
        else
        begin
            summary.status = is_tcp ? ST_TCP_OK : ST_UDP_OK;
        end
        summary.running_sum         = sum_next;
        summary.pending_high_byte   = pend_next;
        summary.odd_tail            = half_next;
        summary.source_address      = src_next;
        summary.destination_address = dst_next;
        summary.protocol_number     = proto_next;
        summary.ip_total_length     = totlen_next;
        summary.header_words        = ihl_next;
        summary.udp_length_field    = udplen_next;
    end

    assign sum_push = accept && word.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            pend_reg   <= '0;
            half_reg   <= 1'b0;
            src_reg    <= '0;
            dst_reg    <= '0;
            proto_reg  <= '0;
            totlen_reg <= '0;
            ihl_reg    <= '0;
            udplen_reg <= '0;
        end
        else if (accept)
        begin
            if (word.last_byte)
            begin
                pos_reg    <= '0;
                sum_reg    <= '0;
                pend_reg   <= '0;
                half_reg   <= 1'b0;
                src_reg    <= '0;
                dst_reg    <= '0;
                proto_reg  <= '0;
                totlen_reg <= '0;
                ihl_reg    <= '0;
                udplen_reg <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                sum_reg    <= sum_next;
                pend_reg   <= pend_next;
                half_reg   <= half_next;
                src_reg    <= src_next;
                dst_reg    <= dst_next;
                proto_reg  <= proto_next;
                totlen_reg <= totlen_next;
                ihl_reg    <= ihl_next;
                udplen_reg <= udplen_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/lpc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpc_back
    import lpc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     sum_empty,
    input  wire summary_t summary,
    output logic          sum_pop,
    input  wire logic     pop,
    output logic          empty,
    output out_word_t     result_word
);

    localparam int RES_W = $clog2(OUT_DEPTH + 1);

    // slots of the result queue taken by stored or in-flight words
    logic [RES_W-1:0] reserved_reg, reserved_next;
    logic             launch, out_pop;

    logic        va_reg, vb_reg;
    logic [1:0]  a_status_reg, b_status_reg;
    logic [31:0] a_sum_reg;
    logic [16:0] a_src_reg, a_dst_reg;
    logic [15:0] a_l4len_reg;
    logic [7:0]  a_proto_reg;
    logic [31:0] b_sum_reg;

    logic [31:0] pad;
    logic [15:0] l4len;
    logic [16:0] fold1;
    logic [15:0] fold2;
    out_word_t   push_word;

    assign out_pop = pop && !empty;
    assign launch  = !sum_empty && ((reserved_reg < RES_W'(OUT_DEPTH)) || out_pop);
    assign sum_pop = launch;

    always_comb
    begin
        case ({launch, out_pop})
            2'b10:   reserved_next = reserved_reg + 1'b1;
            2'b01:   reserved_next = reserved_reg - 1'b1;
            default: reserved_next = reserved_reg;
        endcase
    end

    assign pad   = summary.odd_tail ? {16'h0000, summary.pending_high_byte, 8'h00} : 32'h0;
    assign l4len = (summary.protocol_number == PROTO_TCP)
                 ? summary.ip_total_length - {10'b0, summary.header_words, 2'b00}
                 : summary.udp_length_field;

    assign fold1 = {1'b0, b_sum_reg[15:0]} + {1'b0, b_sum_reg[31:16]};
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    always_comb
    begin
        push_word.status = b_status_reg;
        if (b_status_reg == ST_TCP_OK || b_status_reg == ST_UDP_OK)
        begin
            push_word.checksum = ~fold2;
        end
        else
        begin
            push_word.checksum = 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
        end
        else
        begin
            reserved_reg <= reserved_next;
            va_reg       <= launch;
            vb_reg       <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            a_status_reg <= summary.status;
            a_sum_reg    <= summary.running_sum + pad;
            a_src_reg    <= {1'b0, summary.source_address[31:16]}
                          + {1'b0, summary.source_address[15:0]};
            a_dst_reg    <= {1'b0, summary.destination_address[31:16]}
                          + {1'b0, summary.destination_address[15:0]};
            a_l4len_reg  <= l4len;
            a_proto_reg  <= summary.protocol_number;
        end
        if (va_reg)
        begin
            b_status_reg <= a_status_reg;
            b_sum_reg    <= a_sum_reg + 32'(a_src_reg) + 32'(a_dst_reg)
                          + 32'(a_proto_reg) + 32'(a_l4len_reg);
        end
    end

    lpc_fifo #(
        .W     ($bits(out_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (vb_reg),
        .push_data (push_word),
        .pop       (pop),
        .pop_data  (result_word),
        .empty     (empty),
        .full      ()
    );

endmodule

`default_nettype wire

@@ hdl/l4_packet_checksum.sv @@
`timescale 1ns / 1ps
`default_nettype none

// TCP/UDP over IPv4 checksum engine. Takes one frame byte per cycle while full
// is low, with no gaps needed between frames; frames of any length, one byte
// included, run at one word per cycle in steady state. The L4 part is taken to
// start at frame offset 34 (fixed Ethernet and IPv4 header sizes), the EtherType
// is not looked at, and bytes past MAX_FRAME_BYTES are ignored. Results are
// built in steps: a byte parser keeps the running sum with one 32-bit add per
// byte pair, a two-frame queue hands finished frames to a two-stage finisher
// (pseudo-header add, fold, invert), and a four-word result queue holds
// results until popped. full rises only when two frames wait behind a stalled
// result side. The user must write limit registers only while no frame is in
// progress; the block does not enforce it. cfg_ready is always high.

module l4_packet_checksum
    import lpc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = LPC_MAX_FRAME_BYTES
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire in_word_t              frame_word,
    output logic                       empty,
    input  wire logic                  pop,
    output out_word_t                  result_word,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "l4_packet_checksum_macros.svh"

    cfg_limits_t limits_reg;
    logic        accept;
    logic        sum_push, sum_pop, sum_empty, sum_full;
    summary_t    sum_in, sum_out;
    logic        result_ok;

    assign cfg_ready = 1'b1;
    assign full      = sum_full;
    assign accept    = push && !sum_full;
    assign result_ok = (result_word.status == ST_TCP_OK) || (result_word.status == ST_UDP_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.udp_sum_limit <= UDP_LIMIT_RESET;
            limits_reg.tcp_sum_limit <= TCP_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_UDP_LIMIT: limits_reg.udp_sum_limit <= cfg_data[LIMIT_W-1:0];
                REG_TCP_LIMIT: limits_reg.tcp_sum_limit <= cfg_data[LIMIT_W-1:0];
                default:       ;
            endcase
        end
    end

    lpc_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .word     (frame_word),
        .limits   (limits_reg),
        .sum_push (sum_push),
        .summary  (sum_in)
    );

    lpc_fifo #(
        .W     ($bits(summary_t)),
        .DEPTH (SUM_DEPTH)
    ) u_sum_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sum_push),
        .push_data (sum_in),
        .pop       (sum_pop),
        .pop_data  (sum_out),
        .empty     (sum_empty),
        .full      (sum_full)
    );

    lpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .sum_empty   (sum_empty),
        .summary     (sum_out),
        .sum_pop     (sum_pop),
        .pop         (pop),
        .empty       (empty),
        .result_word (result_word)
    );

    `LPC_ASSERT_NXT(a_frame_queued, clk, rst_n, push && !full && frame_word.last_byte, !sum_empty)
    `LPC_ASSERT_IMP(a_bad_status_zero, clk, rst_n, !empty && !result_ok, result_word.checksum == 16'h0000)

endmodule

`default_nettype wire
